// ----- design/pal_pkg.sv -----
package pal_pkg;

   localparam int FUNC_W   = 3;
   localparam int STATUS_W = 2;
   localparam int POS_W    = 7;
   localparam int KEY_W    = 64;
   localparam int PAY_W    = 32;
   localparam int REQ_W    = 112;
   localparam int RSP_W    = 120;

   localparam logic [FUNC_W-1:0] FUNC_INSERT    = 3'd0;
   localparam logic [FUNC_W-1:0] FUNC_DELETE    = 3'd1;
   localparam logic [FUNC_W-1:0] FUNC_OVERWRITE = 3'd2;
   localparam logic [FUNC_W-1:0] FUNC_READ      = 3'd3;
   localparam logic [FUNC_W-1:0] FUNC_FIND      = 3'd4;

   localparam logic [STATUS_W-1:0] STS_OK    = 2'd0;
   localparam logic [STATUS_W-1:0] STS_FULL  = 2'd1;
   localparam logic [STATUS_W-1:0] STS_RANGE = 2'd2;
   localparam logic [STATUS_W-1:0] STS_MISS  = 2'd3;

   typedef struct packed {
      logic shift_up;
      logic shift_down;
      logic write_new;
   } pal_ctrl_type;

endpackage

// ----- design/pal_cell.sv -----
module pal_cell #(
   parameter int AW    = 7,
   parameter int KW    = 64,
   parameter int PW    = 32,
   parameter int INDEX = 0
) (
   input  logic                  clock,
   input  pal_pkg::pal_ctrl_type ctrl,
   input  logic [AW-1:0]         at,
   input  logic [AW-1:0]         count,
   input  logic [KW-1:0]         new_key,
   input  logic [PW-1:0]         new_pay,
   input  logic [KW-1:0]         prev_key,
   input  logic [PW-1:0]         prev_pay,
   input  logic [KW-1:0]         next_key,
   input  logic [PW-1:0]         next_pay,
   output logic [KW-1:0]         key,
   output logic [PW-1:0]         pay,
   output logic                  match,
   output logic [KW-1:0]         rd_key,
   output logic [PW-1:0]         rd_pay
);
   import pal_pkg::*;

   localparam logic [AW-1:0] IDX = AW'(INDEX);

   logic [KW-1:0] key_ff, key_in, rd_key_ff, rd_key_in;
   logic [PW-1:0] pay_ff, pay_in, rd_pay_ff, rd_pay_in;
   logic          match_ff, match_in;

   always_comb begin
      key_in = key_ff;
      pay_in = pay_ff;
      if (ctrl.shift_up) begin
         if (IDX == at) begin
            key_in = new_key;
            pay_in = new_pay;
         end else if (IDX > at) begin
            key_in = prev_key;
            pay_in = prev_pay;
         end
      end
      if (ctrl.shift_down && IDX >= at) begin
         key_in = next_key;
         pay_in = next_pay;
      end
      if (ctrl.write_new && IDX == at) begin
         key_in = new_key;
         pay_in = new_pay;
      end
      match_in  = (IDX < count) && (key_ff == new_key);
      rd_key_in = (IDX == at) ? key_ff : '0;
      rd_pay_in = (IDX == at) ? pay_ff : '0;
   end

   always_ff @(posedge clock) begin
      key_ff    <= key_in;
      pay_ff    <= pay_in;
      match_ff  <= match_in;
      rd_key_ff <= rd_key_in;
      rd_pay_ff <= rd_pay_in;
   end

   assign key    = key_ff;
   assign pay    = pay_ff;
   assign match  = match_ff;
   assign rd_key = rd_key_ff;
   assign rd_pay = rd_pay_ff;

endmodule

// ----- design/positional_array_list.sv -----
// steps: accept (idle), cell update (apply), reduce; one request word at a time,
// and reduce waits to load the result word while the last one is not taken
// the cell row shifts, overwrites and compares every entry in parallel
// the reduce cycle or-combines read data and picks the first key match
// synchronous active-high reset empties the list; entry contents stay undefined
module positional_array_list #(
   parameter int CAPACITY      = 64,
   parameter int KEY_WIDTH     = 64,
   parameter int PAYLOAD_WIDTH = 32
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_tvalid,
   output logic                      req_tready,
   // func, position, name_key, payload, zero fill
   input  logic [pal_pkg::REQ_W-1:0] req_tdata,
   output logic                      rsp_tvalid,
   input  logic                      rsp_tready,
   // status, entry_key, entry_payload, found_position, length, is_empty, zero fill
   output logic [pal_pkg::RSP_W-1:0] rsp_tdata
);
   import pal_pkg::*;

   localparam int CNT_W = $clog2(CAPACITY + 1);
   localparam int AW    = (CNT_W > POS_W) ? CNT_W : POS_W;
   localparam int KW    = KEY_WIDTH;
   localparam int PW    = (PAYLOAD_WIDTH < PAY_W) ? PAYLOAD_WIDTH : PAY_W;

   typedef enum logic [1:0] {S_IDLE, S_APPLY, S_REDUCE} state_type;

   state_type           state_ff, state_in;
   logic [FUNC_W-1:0]   func_ff, func_in;
   logic [AW-1:0]       at_ff, at_in;
   logic [KW-1:0]       cmd_key_ff, cmd_key_in;
   logic [PW-1:0]       cmd_pay_ff, cmd_pay_in;
   logic                ok_ff, ok_in;
   logic [STATUS_W-1:0] status_ff, status_in;
   logic [CNT_W-1:0]    count_ff, count_in;
   logic                rsp_tvalid_ff, rsp_tvalid_in;
   logic [STATUS_W-1:0] rsp_status_ff, rsp_status_in;
   logic [KEY_W-1:0]    rsp_key_ff, rsp_key_in;
   logic [PAY_W-1:0]    rsp_pay_ff, rsp_pay_in;
   logic [POS_W-1:0]    rsp_fpos_ff, rsp_fpos_in;
   logic [POS_W-1:0]    rsp_len_ff, rsp_len_in;
   logic                rsp_empty_ff, rsp_empty_in;

   logic [FUNC_W-1:0]   req_func;
   logic [POS_W-1:0]    req_pos;
   logic [KEY_W-1:0]    req_key;
   logic [PAY_W-1:0]    req_pay;
   logic [AW-1:0]       pos_ext, req_at, count_ext;
   logic                pos_nz, full;

   pal_ctrl_type        ctrl;
   logic [KW-1:0]       cell_key_w [CAPACITY];
   logic [PW-1:0]       cell_pay_w [CAPACITY];
   logic [KW-1:0]       cell_rd_key_w [CAPACITY];
   logic [PW-1:0]       cell_rd_pay_w [CAPACITY];
   logic [CAPACITY-1:0] match_w, first_w;
   logic [KW-1:0]       rd_key_or;
   logic [PW-1:0]       rd_pay_or;
   logic [AW-1:0]       fpos;
   logic                load;

   assign req_func  = req_tdata[2:0];
   assign req_pos   = req_tdata[9:3];
   assign req_key   = req_tdata[73:10];
   assign req_pay   = req_tdata[105:74];
   assign pos_ext   = AW'(req_pos);
   assign pos_nz    = (req_pos != '0);
   assign req_at    = pos_ext - AW'(1);
   assign count_ext = AW'(count_ff);
   assign full      = (count_ff == CNT_W'(CAPACITY));

   assign ctrl.shift_up   = (state_ff == S_APPLY) && ok_ff && (func_ff == FUNC_INSERT);
   assign ctrl.shift_down = (state_ff == S_APPLY) && ok_ff && (func_ff == FUNC_DELETE);
   assign ctrl.write_new  = (state_ff == S_APPLY) && ok_ff && (func_ff == FUNC_OVERWRITE);

   for (genvar k = 0; k < CAPACITY; k++) begin : g_cell
      logic [KW-1:0] prev_key, next_key;
      logic [PW-1:0] prev_pay, next_pay;
      if (k == 0) begin : g_first
         assign prev_key = cmd_key_ff;
         assign prev_pay = cmd_pay_ff;
      end else begin : g_mid
         assign prev_key = cell_key_w[k-1];
         assign prev_pay = cell_pay_w[k-1];
      end
      if (k == CAPACITY - 1) begin : g_last
         assign next_key = cell_key_w[k];
         assign next_pay = cell_pay_w[k];
      end else begin : g_inner
         assign next_key = cell_key_w[k+1];
         assign next_pay = cell_pay_w[k+1];
      end
      pal_cell #(.AW(AW), .KW(KW), .PW(PW), .INDEX(k)) u_cell (
         .clock    (clock),
         .ctrl     (ctrl),
         .at       (at_ff),
         .count    (count_ext),
         .new_key  (cmd_key_ff),
         .new_pay  (cmd_pay_ff),
         .prev_key (prev_key),
         .prev_pay (prev_pay),
         .next_key (next_key),
         .next_pay (next_pay),
         .key      (cell_key_w[k]),
         .pay      (cell_pay_w[k]),
         .match    (match_w[k]),
         .rd_key   (cell_rd_key_w[k]),
         .rd_pay   (cell_rd_pay_w[k])
      );
   end

   // isolate lowest match, then encode
   assign first_w = match_w & (~match_w + CAPACITY'(1));

   always_comb begin
      rd_key_or = '0;
      rd_pay_or = '0;
      fpos      = '0;
      for (int i = 0; i < CAPACITY; i++) begin
         rd_key_or = rd_key_or | cell_rd_key_w[i];
         rd_pay_or = rd_pay_or | cell_rd_pay_w[i];
         if (first_w[i]) begin
            fpos = fpos | AW'(i + 1);
         end
      end
   end

   assign load = (state_ff == S_REDUCE) && (!rsp_tvalid_ff || rsp_tready);

   always_comb begin
      state_in      = state_ff;
      func_in       = func_ff;
      at_in         = at_ff;
      cmd_key_in    = cmd_key_ff;
      cmd_pay_in    = cmd_pay_ff;
      ok_in         = ok_ff;
      status_in     = status_ff;
      count_in      = count_ff;
      rsp_tvalid_in = rsp_tvalid_ff && !rsp_tready;
      rsp_status_in = rsp_status_ff;
      rsp_key_in    = rsp_key_ff;
      rsp_pay_in    = rsp_pay_ff;
      rsp_fpos_in   = rsp_fpos_ff;
      rsp_len_in    = rsp_len_ff;
      rsp_empty_in  = rsp_empty_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               func_in    = req_func;
               at_in      = req_at;
               cmd_key_in = req_key[KW-1:0];
               cmd_pay_in = req_pay[PW-1:0];
               case (req_func)
                  FUNC_INSERT: begin
                     if (!pos_nz || req_at > count_ext) begin
                        status_in = STS_RANGE;
                     end else if (full) begin
                        status_in = STS_FULL;
                     end else begin
                        status_in = STS_OK;
                     end
                  end
                  FUNC_DELETE, FUNC_OVERWRITE, FUNC_READ: begin
                     status_in = (pos_nz && req_at < count_ext) ? STS_OK : STS_RANGE;
                  end
                  default: begin
                     status_in = STS_OK;
                  end
               endcase
               ok_in    = (status_in == STS_OK);
               state_in = S_APPLY;
            end
         end
         S_APPLY: begin
            if (ok_ff && func_ff == FUNC_INSERT) begin
               count_in = count_ff + CNT_W'(1);
            end else if (ok_ff && func_ff == FUNC_DELETE) begin
               count_in = count_ff - CNT_W'(1);
            end
            state_in = S_REDUCE;
         end
         S_REDUCE: begin
            if (load) begin
               rsp_tvalid_in = 1'b1;
               rsp_status_in = status_ff;
               rsp_key_in    = '0;
               rsp_pay_in    = '0;
               rsp_fpos_in   = '0;
               if (func_ff == FUNC_FIND) begin
                  rsp_status_in = (match_w != '0) ? STS_OK : STS_MISS;
                  rsp_fpos_in   = fpos[POS_W-1:0];
               end
               if (func_ff == FUNC_READ && ok_ff) begin
                  rsp_key_in = KEY_W'(rd_key_or);
                  rsp_pay_in = PAY_W'(rd_pay_or);
               end
               rsp_len_in   = count_ext[POS_W-1:0];
               rsp_empty_in = (count_ff == '0);
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      func_ff       <= func_in;
      at_ff         <= at_in;
      cmd_key_ff    <= cmd_key_in;
      cmd_pay_ff    <= cmd_pay_in;
      ok_ff         <= ok_in;
      status_ff     <= status_in;
      rsp_status_ff <= rsp_status_in;
      rsp_key_ff    <= rsp_key_in;
      rsp_pay_ff    <= rsp_pay_in;
      rsp_fpos_ff   <= rsp_fpos_in;
      rsp_len_ff    <= rsp_len_in;
      rsp_empty_ff  <= rsp_empty_in;
      if (reset) begin
         state_ff      <= S_IDLE;
         count_ff      <= '0;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         count_ff      <= count_in;
         rsp_tvalid_ff <= rsp_tvalid_in;
      end
   end

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = {7'd0, rsp_empty_ff, rsp_len_ff, rsp_fpos_ff,
                        rsp_pay_ff, rsp_key_ff, rsp_status_ff};

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(CAPACITY))
      else $error("entry count above capacity");

   a_count_apply: assert property (@(posedge clock) disable iff (reset)
      (count_ff != $past(count_ff)) |-> ($past(state_ff) == S_APPLY))
      else $error("entry count changed outside apply cycle");

   a_valid_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid_ff) |-> ($past(state_ff) == S_REDUCE))
      else $error("result word raised outside reduce cycle");

   a_fail_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid_ff && rsp_status_ff != STS_OK) |-> (rsp_key_ff == '0 && rsp_pay_ff == '0))
      else $error("failed operation returned entry data");

endmodule
